FILE: rtl/core/sbus_fd_pkg.sv
// ----------------------------------------------------------------------------
// sbus_fd_pkg
// Shared constants and types of the SBUS frame decoder.
// ----------------------------------------------------------------------------
package sbus_fd_pkg;

  localparam int unsigned FrameLength = 25;
  localparam int unsigned LastPos     = FrameLength - 1;
  // Channel bytes 1 to 22 go to the frame store; byte 0 is kept in a register.
  localparam int unsigned StoredBytes = 22;
  localparam int unsigned PosW        = 5;
  localparam int unsigned IdxW        = 5;
  localparam int unsigned ChanCount   = 16;
  localparam int unsigned ChanW       = 11;
  localparam int unsigned ChanIdxW    = 4;
  localparam int unsigned ChanOffset  = 1024;
  localparam int unsigned AccW        = 18;
  localparam int unsigned CntW        = 5;

  typedef enum logic [0:0] {
    RegStartByte = 1'b0,
    RegEndByte   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic start;
    logic bank;
  } handoff_t;

  typedef struct packed {
    logic            en;
    logic            bank;
    logic [IdxW-1:0] idx;
  } rd_req_t;

endpackage

FILE: rtl/core/sbus_fd_store.sv
// ----------------------------------------------------------------------------
// sbus_fd_store
// Two-bank frame byte store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sbus_fd_store
  import sbus_fd_pkg::*;
(
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic            wr_bank_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  logic [7:0]      wr_data_i,
  input  rd_req_t         rd_req_i,
  output logic [7:0]      rd_data_o
);

  logic [7:0] mem_q [2][StoredBytes];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_bank_i][wr_idx_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req_i.en) begin
      rd_data_o <= mem_q[rd_req_i.bank][rd_req_i.idx];
    end
  end

endmodule

FILE: rtl/core/sbus_fd_unpack.sv
// ----------------------------------------------------------------------------
// sbus_fd_unpack
// Reads a finished frame from the store and shifts out sixteen channels.
// ----------------------------------------------------------------------------
module sbus_fd_unpack
  import sbus_fd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  handoff_t                 handoff_i,
  output rd_req_t                  rd_req_o,
  input  logic [7:0]               rd_data_i,
  output logic                     busy_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [ChanIdxW-1:0]      channel_index_o,
  output logic signed [ChanW-1:0]  channel_value_o,
  output logic                     last_channel_o
);

  logic                busy_q, busy_d;
  logic                rbank_q, rbank_d;
  logic [IdxW-1:0]     rd_idx_q, rd_idx_d;
  logic                rd_pend_q, rd_pend_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [ChanIdxW-1:0] ch_q, ch_d;
  logic                out_valid_q;
  logic                out_free, emit, issue, ch_last;
  logic [ChanW-1:0]    raw;

  assign out_free = ~out_valid_q | out_ready_i;
  assign ch_last  = (ch_q == ChanIdxW'(ChanCount - 1));
  assign emit     = busy_q & (cnt_q >= CntW'(ChanW)) & out_free;
  // A read goes out only while fewer than one channel's bits are held.
  assign issue    = busy_q & (cnt_q < CntW'(ChanW)) & ~rd_pend_q &
                    (rd_idx_q < IdxW'(StoredBytes));
  assign raw      = acc_q[ChanW-1:0];

  assign rd_req_o = '{en: issue, bank: rbank_q, idx: rd_idx_q};
  assign busy_o   = busy_q;

  always_comb begin
    busy_d    = busy_q;
    rbank_d   = rbank_q;
    rd_idx_d  = rd_idx_q;
    rd_pend_d = rd_pend_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    ch_d      = ch_q;
    if (handoff_i.start) begin
      busy_d    = 1'b1;
      rbank_d   = handoff_i.bank;
      rd_idx_d  = '0;
      rd_pend_d = 1'b0;
      acc_d     = '0;
      cnt_d     = '0;
      ch_d      = '0;
    end else begin
      if (issue) begin
        rd_idx_d  = rd_idx_q + IdxW'(1);
        rd_pend_d = 1'b1;
      end
      // Read data and a channel emit never fall in the same cycle.
      if (rd_pend_q) begin
        rd_pend_d = 1'b0;
        acc_d     = acc_q | (AccW'(rd_data_i) << cnt_q);
        cnt_d     = cnt_q + CntW'(8);
      end
      if (emit) begin
        acc_d = acc_q >> ChanW;
        cnt_d = cnt_q - CntW'(ChanW);
        ch_d  = ch_q + ChanIdxW'(1);
        if (ch_last) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      rd_pend_q <= rd_pend_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rbank_q  <= rbank_d;
    rd_idx_q <= rd_idx_d;
    acc_q    <= acc_d;
    cnt_q    <= cnt_d;
    ch_q     <= ch_d;
    if (emit) begin
      channel_index_o <= ch_q;
      channel_value_o <= raw - ChanW'(ChanOffset);
      last_channel_o  <= ch_last;
    end
  end

  assign out_valid_o = out_valid_q;

  a_handoff_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    handoff_i.start |-> !busy_q)
    else $error("frame handed over while the previous one still drains");

  a_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> busy_q)
    else $error("store read in flight outside a drain");

  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= CntW'(AccW))
    else $error("bit accumulator overflow");

  a_last_spent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && ch_last) |-> (rd_idx_q == IdxW'(StoredBytes) && cnt_q == CntW'(ChanW)
                           && !rd_pend_q))
    else $error("last channel emitted with frame bits left over");

endmodule

FILE: rtl/core/sbus_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder_unit
// SBUS frame decoder: byte assembly, frame check and channel unpacking.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one transaction per received serial byte
// (command_i = 0) or per line-idle event (command_i = 1, restarts the frame).
// Bytes 1 to 22 are written into one bank of a two-bank frame store. When the
// 25th byte arrives and byte 0 and byte 24 match start_byte and end_byte, the
// bank is handed to the unpacker and the next frame fills the other bank.
// The output channel then gives sixteen transactions, one per channel, value
// minus 1024, with last_channel_o set on the sixteenth.
// Input throughput is one byte per cycle while in_ready_o is high. The
// unpacker issues a store read only once the data of its last read has
// returned and while it holds fewer than one channel's bits; it reads two
// bytes before it registers the first channel on the output. If a new end
// byte arrives while the previous frame still drains, in_ready_o stays low
// for that byte only. A stalled output holds the unpacker, and so a later end byte.
// Reset clears the byte position, the drain state and the output valid and
// loads start_byte = 15, end_byte = 0. Configuration writes take effect at
// once; the user must make them while the block is idle; nothing checks it.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_unit
  import sbus_fd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [0:0]              cfg_index_i,
  input  logic [7:0]              cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    command_i,
  input  logic [7:0]              data_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ChanIdxW-1:0]     channel_index_o,
  output logic signed [ChanW-1:0] channel_value_o,
  output logic                    last_channel_o
);

  logic [7:0]      start_q, end_q, first_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic            wbank_q, wbank_d;
  logic            busy, at_end, byte_acc, idle_acc, frame_good, wr_en;
  logic [IdxW-1:0] wr_idx;
  handoff_t        handoff;
  rd_req_t         rd_req;
  logic [7:0]      rd_data;

  assign at_end     = (pos_q == PosW'(LastPos));
  assign in_ready_o = ~(~command_i & at_end & busy);
  assign byte_acc   = in_valid_i & in_ready_o & ~command_i;
  assign idle_acc   = in_valid_i & in_ready_o & command_i;
  assign frame_good = byte_acc & at_end & (first_q == start_q) & (data_byte_i == end_q);
  assign wr_en      = byte_acc & (pos_q != '0) & (pos_q <= PosW'(StoredBytes));
  assign wr_idx     = IdxW'(pos_q - PosW'(1));
  assign handoff    = '{start: frame_good, bank: wbank_q};

  always_comb begin
    pos_d   = pos_q;
    wbank_d = wbank_q;
    if (idle_acc) begin
      pos_d = '0;
    end else if (byte_acc) begin
      pos_d = at_end ? '0 : pos_q + PosW'(1);
    end
    if (frame_good) begin
      wbank_d = ~wbank_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      wbank_q <= 1'b0;
      start_q <= 8'd15;
      end_q   <= 8'd0;
    end else begin
      pos_q   <= pos_d;
      wbank_q <= wbank_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          RegStartByte: start_q <= cfg_wdata_i;
          RegEndByte:   end_q   <= cfg_wdata_i;
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_acc && pos_q == '0) begin
      first_q <= data_byte_i;
    end
  end

  sbus_fd_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_bank_i (wbank_q),
    .wr_idx_i  (wr_idx),
    .wr_data_i (data_byte_i),
    .rd_req_i  (rd_req),
    .rd_data_o (rd_data)
  );

  sbus_fd_unpack u_unpack (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .handoff_i       (handoff),
    .rd_req_o        (rd_req),
    .rd_data_i       (rd_data),
    .busy_o          (busy),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .last_channel_o  (last_channel_o)
  );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the SBUS frame decoder unit.
// A table of directed frames, line-idle events and register writes runs first.
// Random frames follow, mostly well formed and some broken or cut short.
// A model of byte position and frame store predicts the channels, but for
// directed rows that list them; each output transaction is checked against
// the oldest expected one. Both handshakes idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
  import sbus_fd_pkg::*;

  localparam logic CmdByte = 1'b0;
  localparam logic CmdIdle = 1'b1;
  localparam int   FlagPos = 23;
  localparam int   UsePredictor = -1;
  localparam int   RandItems = 160;
  localparam int   IdleSettle = 16;
  localparam int   EndSettle = 80;
  localparam int   HoldCycles = 300;
  localparam int   CycleLimit = 200000;
  localparam logic signed [ChanW-1:0] ChanMin = -11'sd1024;
  localparam logic signed [ChanW-1:0] ChanMax = 11'sd1023;

  typedef enum int {RowFrame, RowIdle, RowConfig} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [7:0]               head;     // byte 0, or start_byte for a write
    logic [7:0]               fill;     // channel bytes, or data of an idle
    bit                       fill_rnd;
    logic [7:0]               tail;     // byte 24, or end_byte for a write
    int                       cut;      // nonzero: bytes sent before a line idle
    int                       exp_n;
    logic signed [ChanW-1:0]  exp_val;
  } stim_row_t;

  typedef struct packed {
    logic [ChanIdxW-1:0]     idx;
    logic signed [ChanW-1:0] val;
    logic                    last;
  } chan_t;

  stim_row_t dir_rows [0:14] = '{
    '{RowFrame,  8'h0F, 8'h00, 1'b0, 8'h00, 0,  ChanCount,    ChanMin},
    '{RowFrame,  8'h0F, 8'hFF, 1'b0, 8'h00, 0,  ChanCount,    ChanMax},
    '{RowFrame,  8'h0F, 8'h00, 1'b1, 8'h00, 0,  UsePredictor, ChanMin},
    '{RowFrame,  8'h0E, 8'h00, 1'b1, 8'h00, 0,  0,            ChanMin},
    '{RowFrame,  8'h0F, 8'h00, 1'b1, 8'h01, 0,  0,            ChanMin},
    '{RowFrame,  8'h0F, 8'h00, 1'b1, 8'h00, 24, 0,            ChanMin},
    '{RowIdle,   8'h00, 8'hFF, 1'b0, 8'h00, 0,  0,            ChanMin},
    '{RowFrame,  8'h0F, 8'h00, 1'b1, 8'h00, 0,  UsePredictor, ChanMin},
    '{RowConfig, 8'h00, 8'h00, 1'b0, 8'hFF, 0,  0,            ChanMin},
    '{RowFrame,  8'h00, 8'hFF, 1'b0, 8'hFF, 0,  ChanCount,    ChanMax},
    '{RowFrame,  8'h0F, 8'h00, 1'b0, 8'hFF, 0,  0,            ChanMin},
    '{RowConfig, 8'hFF, 8'h00, 1'b0, 8'h00, 0,  0,            ChanMin},
    '{RowFrame,  8'hFF, 8'h00, 1'b0, 8'h00, 0,  ChanCount,    ChanMin},
    '{RowFrame,  8'hFF, 8'h00, 1'b1, 8'hFF, 0,  0,            ChanMin},
    '{RowFrame,  8'hFF, 8'h00, 1'b1, 8'h00, 0,  UsePredictor, ChanMin}
  };

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = RegStartByte;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid = 1'b0;
  logic       command = CmdByte;
  logic [7:0] data_byte = 8'h00;
  logic       out_ready = 1'b0;

  logic                    in_ready;
  logic                    out_valid;
  logic [ChanIdxW-1:0]     channel_index;
  logic signed [ChanW-1:0] channel_value;
  logic                    last_channel;

  // Predictor state.
  logic [7:0]    start_cfg = 8'h0F;
  logic [7:0]    end_cfg = 8'h00;
  logic [PosW-1:0] byte_pos = '0;
  logic [7:0]    frame_store [0:FlagPos-1];
  chan_t         pending_chans [$];

  bit  typed_row = 1'b0;
  bit  idle_on = 1'b0;
  bit  final_part = 1'b0;
  bit  hold_req = 1'b0;
  int  sent_items = 0;
  int  fail_cnt = 0;
  int  cycle_cnt = 0;

  sbus_frame_decoder_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .command_i       (command),
    .data_byte_i     (data_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .channel_index_o (channel_index),
    .channel_value_o (channel_value),
    .last_channel_o  (last_channel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Tracks one accepted transaction and queues a good frame's channels unless typed_row.
  task automatic decode_step(input logic cmd, input logic [7:0] data);
    logic [ChanCount*ChanW-1:0] stream;
    logic [ChanW-1:0]           raw;
    chan_t                      chan;
    int                         k;
    if (cmd == CmdIdle) begin
      byte_pos = '0;
    end else if (byte_pos < LastPos) begin
      if (byte_pos < FlagPos) frame_store[byte_pos] = data;
      byte_pos = byte_pos + 1'b1;
    end else begin
      byte_pos = '0;
      if (frame_store[0] == start_cfg && data == end_cfg && !typed_row) begin
        for (k = 1; k < FlagPos; k++) stream[(k-1)*8 +: 8] = frame_store[k];
        for (k = 0; k < ChanCount; k++) begin
          raw = stream[k*ChanW +: ChanW];
          chan.idx = ChanIdxW'(k);
          chan.val = ChanW'(raw - ChanOffset);
          chan.last = (k == ChanCount - 1);
          pending_chans.push_back(chan);
        end
      end
    end
  endtask

  task automatic send_item(input logic cmd, input logic [7:0] data);
    if (idle_on && !final_part && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    data_byte <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
    decode_step(cmd, data);
  endtask

  task automatic send_frame(input logic [7:0] head, input logic [7:0] fill,
                            input bit fill_rnd, input logic [7:0] tail, input int cut);
    logic [7:0] b;
    int         p;
    for (p = 0; p < FrameLength && (cut == 0 || p < cut); p++) begin
      if (p == 0) b = head;
      else if (p == LastPos) b = tail;
      else if (fill_rnd || p == FlagPos) b = 8'($urandom_range(0, 255));
      else b = fill;
      send_item(CmdByte, b);
    end
    if (cut != 0) send_item(CmdIdle, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_chans.size() != 0) @(posedge clk);
    repeat (IdleSettle) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] sb, input logic [7:0] eb);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= RegStartByte;
    cfg_wdata <= sb;
    @(posedge clk);
    start_cfg = sb;
    cfg_index <= RegEndByte;
    cfg_wdata <= eb;
    @(posedge clk);
    end_cfg = eb;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_cfg_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Output side: checks each transaction and drives ready with stalls and holds.
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    chan_t got;
    chan_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{channel_index, channel_value, last_channel};
        if (pending_chans.size() == 0) begin
          $display("%0t: unexpected channel: got idx %0d value %0d last %0b",
                   $time, got.idx, got.val, got.last);
          fail_cnt++;
        end else begin
          want = pending_chans.pop_front();
          if (got != want) begin
            $display("%0t: mismatch: exp idx %0d val %0d last %0b, got idx %0d val %0d last %0b",
                     $time, want.idx, want.val, want.last, got.idx, got.val, got.last);
            fail_cnt++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && !final_part && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int r;
    int i;
    int rand_base;
    int seq;
    int pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < $size(dir_rows); r++) begin
      idle_on = ($urandom_range(0, 2) != 0);
      case (dir_rows[r].kind)
        RowConfig: set_config(dir_rows[r].head, dir_rows[r].tail);
        RowIdle:   send_item(CmdIdle, dir_rows[r].fill);
        default: begin
          typed_row = (dir_rows[r].exp_n != UsePredictor);
          send_frame(dir_rows[r].head, dir_rows[r].fill, dir_rows[r].fill_rnd,
                     dir_rows[r].tail, dir_rows[r].cut);
          if (typed_row) begin
            for (i = 0; i < dir_rows[r].exp_n; i++)
              pending_chans.push_back('{ChanIdxW'(i), dir_rows[r].exp_val,
                                        i == ChanCount - 1});
          end
          typed_row = 1'b0;
        end
      endcase
    end

    rand_base = sent_items;
    seq = 0;
    while (sent_items - rand_base < RandItems) begin
      final_part = (sent_items - rand_base >= RandItems - 50);
      idle_on = !final_part && $urandom_range(0, 3) != 0;
      if (seq == 2) begin
        // Hold the output long enough that the second end byte must wait.
        wait_drained();
        hold_req = 1'b1;
        idle_on = 1'b0;
        send_frame(start_cfg, 8'h00, 1'b1, end_cfg, 0);
        send_frame(start_cfg, 8'h00, 1'b1, end_cfg, 0);
      end else if (seq % 4 == 3 && !final_part) begin
        set_config(pick_cfg_byte(), pick_cfg_byte());
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
          if ($urandom_range(0, 2) == 0) send_item(CmdIdle, 8'($urandom_range(0, 255)));
          send_frame(start_cfg, 8'h00, 1'b1, end_cfg, 0);
        end else if (pick < 16) begin
          send_frame(start_cfg ^ 8'($urandom_range(1, 255)), 8'h00, 1'b1, end_cfg, 0);
        end else if (pick < 18) begin
          send_frame(start_cfg, 8'h00, 1'b1, end_cfg ^ 8'($urandom_range(1, 255)), 0);
        end else if (pick == 18) begin
          send_frame(start_cfg, 8'h00, 1'b1, end_cfg, $urandom_range(1, LastPos));
        end else begin
          repeat ($urandom_range(1, 10)) send_item(CmdByte, 8'($urandom_range(0, 255)));
          send_item(CmdIdle, 8'($urandom_range(0, 255)));
        end
      end
      seq++;
    end

    in_valid <= 1'b0;
    while (pending_chans.size() != 0) @(posedge clk);
    repeat (EndSettle) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sbus_fd_pkg.sv
rtl/core/sbus_fd_store.sv
rtl/core/sbus_fd_unpack.sv
rtl/core/sbus_frame_decoder_unit.sv
tb/sv/tb_top.sv
